>>> rtl/sld_pkg.sv
// Shared constants and types for the slew-limited motor drive.
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

   localparam int POS_W  = 11;
   localparam int DUTY_W = 8;
   localparam int DIST_W = 10;

   localparam logic [POS_W-1:0]  POS_CENTRE = 11'd1000;
   localparam logic [POS_W-1:0]  POS_MAX    = 11'd2000;
   localparam logic [POS_W-1:0]  BAND_HIGH  = 11'd1040;
   localparam logic [POS_W-1:0]  BAND_LOW   = 11'd960;
   localparam logic [DUTY_W-1:0] DUTY_MAX   = 8'd250;

   localparam logic [POS_W-1:0]  RATE_RESET = 11'd2000;

   // request kinds carried on req_tuser
   typedef enum logic [0:0] {
      REQ_SLEW = 1'b0,
      REQ_STOP = 1'b1
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      REG_FAST_SLEW = 1'b0,
      REG_SLOW_SLEW = 1'b1
   } reg_idx_type;

endpackage : sld_pkg

`default_nettype wire

>>> rtl/slew_limited_motor_drive.sv
// Slew-limited motor position with PWM duty and H-bridge direction outputs.
// A request passes through the input register and then the result register before
// rsp_tvalid rises; a stalled result register holds it in the input register.
// Throughput: one item per cycle unless rsp_tready stalls; the kept position updates as
// an item leaves the input register, so the following item sees it in the next cycle.
// Reset (synchronous): position 1000, both slew rates 2000, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module slew_limited_motor_drive
   import sld_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration writes
   input  wire logic                   csr_we,
   input  wire logic [0:0]             csr_addr,
   input  wire logic [POS_W-1:0]       csr_wdata,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [15:0]            req_tdata,  // [10:0] target position, [15:11] zero
   input  wire logic [0:0]             req_tuser,  // [0] req_type
   // result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [23:0]                 rsp_tdata   // [10:0] motor_position, [18:11] pwm_duty,
                                                   // [19] drive_forward, [20] drive_reverse,
                                                   // [23:21] zero
);

   logic [POS_W-1:0]  fast_rate_ff;
   logic [POS_W-1:0]  slow_rate_ff;
   logic [POS_W-1:0]  position_ff;
   logic [POS_W-1:0]  position_in;

   logic              in_vld_ff;
   req_kind_type      in_kind_ff;
   logic [POS_W-1:0]  in_cmd_ff;

   logic              out_vld_ff;
   logic [POS_W-1:0]  out_pos_ff;
   logic [DUTY_W-1:0] out_duty_ff;
   logic              out_fwd_ff;
   logic              out_rev_ff;

   logic              out_free;
   logic              in_fire;

   logic              moving_up;
   logic [POS_W-1:0]  diff;
   logic [POS_W-1:0]  limit;
   logic [POS_W-1:0]  step;
   logic [POS_W:0]    sum;
   logic [POS_W-1:0]  slew_pos;
   logic [DIST_W-1:0] center_offset;
   logic [DUTY_W-1:0] duty_in;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign in_fire    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_rate_ff <= RATE_RESET;
         slow_rate_ff <= RATE_RESET;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_addr))
            REG_FAST_SLEW: fast_rate_ff <= csr_wdata;
            REG_SLOW_SLEW: slow_rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_kind_type'(req_tuser[0]);
         in_cmd_ff  <= req_tdata[POS_W-1:0];
      end
   end

   // slew step: slow rate when heading back toward centre, fast otherwise
   always_comb begin
      moving_up = in_cmd_ff > position_ff;
      diff      = moving_up ? (in_cmd_ff - position_ff) : (position_ff - in_cmd_ff);
      if (moving_up) begin
         limit = (position_ff < POS_CENTRE) ? slow_rate_ff : fast_rate_ff;
      end else begin
         limit = (position_ff > POS_CENTRE) ? slow_rate_ff : fast_rate_ff;
      end
      step = (diff > limit) ? limit : diff;
      sum  = {1'b0, position_ff} + {1'b0, step};
      if (moving_up) begin
         slew_pos = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
      end else begin
         slew_pos = (step > position_ff) ? '0 : (position_ff - step);
      end
   end

   assign position_in = (in_kind_ff == REQ_STOP) ? POS_CENTRE : slew_pos;

   // duty from distance to centre; position stays within 0..2000 so it fits 10 bits
   always_comb begin
      center_offset = (position_in >= POS_CENTRE) ? DIST_W'(position_in - POS_CENTRE)
                                                  : DIST_W'(POS_CENTRE - position_in);
      duty_in = (center_offset[DIST_W-1:2] > DUTY_MAX) ? DUTY_MAX
                                                       : center_offset[DIST_W-1:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= POS_CENTRE;
      end else if (in_fire) begin
         position_ff <= position_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         out_pos_ff  <= position_in;
         out_duty_ff <= duty_in;
         out_fwd_ff  <= position_in > BAND_HIGH;
         out_rev_ff  <= position_in < BAND_LOW;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, out_rev_ff, out_fwd_ff, out_duty_ff, out_pos_ff};

endmodule : slew_limited_motor_drive

`default_nettype wire
